/* sv/qnds_pkg.sv */
// shared types, constants and character helpers for the quoted nested delimiter splitter
package qnds_pkg;

    localparam int DELIM_MAX  = 8;
    localparam int WIN_DEPTH  = DELIM_MAX + 1;
    localparam int FILL_BITS  = $clog2(WIN_DEPTH + 1);
    localparam int DROP_BITS  = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
    localparam int LEVEL_BITS = 16;

    localparam logic signed [LEVEL_BITS-1:0] LVL_MAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};
    localparam logic signed [LEVEL_BITS-1:0] LVL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};
    localparam logic signed [LEVEL_BITS-1:0] LVL_ONE = {{(LEVEL_BITS-1){1'b0}}, 1'b1};

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [1:0] {
        CFG_DELIM_BYTES = 2'd0,
        CFG_DELIM_LEN   = 2'd1,
        CFG_SEP_MODE    = 2'd2
    } cfg_reg_t;

    function automatic logic [7:0] ascii_lower(input logic [7:0] c);
        ascii_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        is_sep = (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB)
            || (c == CH_COMMA);
    endfunction

endpackage

/* sv/quoted_nested_delimiter_splitter.sv */
// top level of the quoted nested delimiter splitter: window, parse state and result register
//
// Splits a byte stream into segments at a configured delimiter of 1 to 8 characters.
// Each input beat carries one byte; a result beat carries either one segment byte or a
// segment end marker, and the last result of every string has tlast set. While a string
// runs, one byte is decided per cycle, so input beats are taken back to back and each
// beat yields at most one result in the cycle after it. A beat with tlast set holds the
// input while the bytes left in the lookahead window are decided one per cycle, then the
// closing segment end goes out. Shortening the delimiter while a string runs leaves
// extra bytes in the window that are decided one per cycle after the next beat, with
// the input held meanwhile. Back pressure on the result side stalls the window logic.
// A delimiter whose first byte is a backslash, a quote or an open parenthesis discards
// the input and reports an error on the closing result.
module quoted_nested_delimiter_splitter
    import qnds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // text_byte
    input  logic        s_tlast,    // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte
    output logic        m_tlast,    // final_result
    output logic [1:0]  m_tuser,    // segment_end, delimiter_error
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] delim_reg;
    logic [3:0]  dlen_reg;
    logic        sep_mode_reg;

    logic [7:0]  win_reg [WIN_DEPTH];
    logic [7:0]  win_next [WIN_DEPTH];
    logic [7:0]  wk [WIN_DEPTH];
    logic [FILL_BITS-1:0] fill_reg, fill_next, wk_fill;
    logic        quotes_reg, quotes_next;
    logic        esc_reg, esc_next;
    logic        pws_reg, pws_next;
    logic signed [LEVEL_BITS-1:0] level_reg, level_next, level_tmp;
    logic [DROP_BITS-1:0] drop_reg, drop_next;
    logic        busy_reg, busy_next;
    logic        flush_reg, flush_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_seg_reg, out_seg_next;
    logic        out_fin_reg, out_fin_next;
    logic        out_err_reg, out_err_next;

    logic [3:0]  len;
    logic [FILL_BITS-1:0] len_plus;
    logic        out_free;
    logic        step;
    logic        wk_end;
    logic        bad_delim;
    logic        need;
    logic [DELIM_MAX-1:0] ok;
    logic        match;
    logic        after;
    logic        take;
    logic        emit;
    logic [7:0]  emit_byte;
    logic [7:0]  head;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg    <= 64'd44;
            dlen_reg     <= 4'd1;
            sep_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DELIM_BYTES: delim_reg    <= cfg_data;
                CFG_DELIM_LEN:   dlen_reg     <= cfg_data[3:0];
                CFG_SEP_MODE:    sep_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // effective delimiter length
    always_comb
    begin
        if (dlen_reg == 4'd0)
            len = 4'd1;
        else if (dlen_reg > 4'(DELIM_MAX))
            len = 4'(DELIM_MAX);
        else
            len = dlen_reg;
        len_plus = FILL_BITS'(len) + FILL_BITS'(1);
    end

    assign bad_delim = (delim_reg[7:0] == CH_BSLASH) || (delim_reg[7:0] == CH_QUOTE)
        || (delim_reg[7:0] == CH_LPAREN);

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = out_free && !busy_reg;
    assign step     = out_free && (busy_reg || s_tvalid);

    // working window: stored bytes plus the incoming beat
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            wk[i] = (!busy_reg && FILL_BITS'(i) == fill_reg) ? s_tdata : win_reg[i];
        end
        if (busy_reg)
            wk_fill = fill_reg;
        else if (fill_reg < FILL_BITS'(WIN_DEPTH))
            wk_fill = fill_reg + FILL_BITS'(1);
        else
            wk_fill = fill_reg;
        wk_end = busy_reg ? flush_reg : s_tlast;
        need   = wk_end ? (wk_fill != '0) : (wk_fill >= len_plus);
        head   = wk[0];
    end

    // parallel delimiter compare against the window
    always_comb
    begin
        for (int i = 0; i < DELIM_MAX; i++)
        begin
            ok[i] = (4'(i) >= len) || ((FILL_BITS'(i) < wk_fill)
                && (ascii_lower(wk[i]) == delim_reg[8*i +: 8]));
        end
        match = &ok;
        after = (wk_fill == FILL_BITS'(len)) ? wk_end : is_sep(wk[len]);
    end

    // decision about the oldest window byte
    always_comb
    begin
        quotes_next = quotes_reg;
        esc_next    = esc_reg;
        pws_next    = pws_reg;
        level_next  = level_reg;
        level_tmp   = level_reg;
        drop_next   = drop_reg;
        take        = 1'b0;
        emit        = 1'b0;
        emit_byte   = head;
        if (drop_reg != '0)
        begin
            drop_next = drop_reg - DROP_BITS'(1);
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            emit     = 1'b1;
        end
        else if (head == CH_BSLASH)
        begin
            esc_next = 1'b1;
            emit     = 1'b1;
        end
        else if (head == CH_QUOTE)
        begin
            quotes_next = !quotes_reg;
            pws_next    = 1'b0;
            emit        = 1'b1;
        end
        else if (quotes_reg)
        begin
            emit = 1'b1;
        end
        else
        begin
            if (head == CH_LPAREN && level_reg != LVL_MAX)
                level_tmp = level_reg + LVL_ONE;
            else if (head == CH_RPAREN && level_reg != LVL_MIN)
                level_tmp = level_reg - LVL_ONE;
            level_next = level_tmp;
            if (level_tmp == '0 && match)
            begin
                if (sep_mode_reg)
                begin
                    if (pws_reg && after)
                    begin
                        pws_next = 1'b0;
                        take     = 1'b1;
                    end
                end
                else
                begin
                    take = 1'b1;
                end
            end
            emit = 1'b1;
            if (take)
            begin
                drop_next = DROP_BITS'(len - 4'd1);
                emit_byte = 8'd0;
            end
            else if (level_tmp == '0 && sep_mode_reg)
            begin
                pws_next = is_sep(head);
            end
        end
    end

    // step control, window update and result load
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_next[i] = wk[i];
        end
        fill_next      = fill_reg;
        busy_next      = busy_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_seg_next   = out_seg_reg;
        out_fin_next   = out_fin_reg;
        out_err_next   = out_err_reg;
        if (step)
        begin
            if (!busy_reg && bad_delim)
            begin
                fill_next  = '0;
                busy_next  = 1'b0;
                flush_next = 1'b0;
                if (s_tlast)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'd0;
                    out_seg_next   = 1'b1;
                    out_fin_next   = 1'b1;
                    out_err_next   = 1'b1;
                end
            end
            else if (need)
            begin
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                begin
                    win_next[i] = wk[i+1];
                end
                fill_next  = wk_fill - FILL_BITS'(1);
                flush_next = wk_end;
                busy_next  = wk_end || (fill_next >= len_plus);
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = emit_byte;
                    out_seg_next   = take;
                    out_fin_next   = 1'b0;
                    out_err_next   = 1'b0;
                end
            end
            else if (wk_end)
            begin
                fill_next      = '0;
                busy_next      = 1'b0;
                flush_next     = 1'b0;
                out_valid_next = 1'b1;
                out_byte_next  = 8'd0;
                out_seg_next   = 1'b1;
                out_fin_next   = 1'b1;
                out_err_next   = 1'b0;
            end
            else
            begin
                fill_next = wk_fill;
                busy_next = 1'b0;
            end
        end
    end

    // parse state, cleared at string end and on a bad delimiter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            quotes_reg    <= 1'b0;
            esc_reg       <= 1'b0;
            pws_reg       <= 1'b1;
            level_reg     <= '0;
            drop_reg      <= '0;
            busy_reg      <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            busy_reg      <= busy_next;
            flush_reg     <= flush_next;
            if (step)
            begin
                if ((!busy_reg && bad_delim) || (!need && wk_end))
                begin
                    quotes_reg <= 1'b0;
                    esc_reg    <= 1'b0;
                    pws_reg    <= 1'b1;
                    level_reg  <= '0;
                    drop_reg   <= '0;
                end
                else if (need)
                begin
                    quotes_reg <= quotes_next;
                    esc_reg    <= esc_next;
                    pws_reg    <= pws_next;
                    level_reg  <= level_next;
                    drop_reg   <= drop_next;
                end
            end
        end
    end

    // window bytes and result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
        out_byte_reg <= out_byte_next;
        out_seg_reg  <= out_seg_next;
        out_fin_reg  <= out_fin_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_fin_reg;
    assign m_tuser  = {out_err_reg, out_seg_reg};

    // no input beat is taken while the window drains
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_tready)
        else $error("input taken while window drains");

    // the window never holds more than the maximum delimiter length plus one bytes
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(WIN_DEPTH))
        else $error("window fill out of range");

    // a closing beat is always a segment end
    a_final_is_seg_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("closing beat without segment end");

    // the error flag only appears on a closing beat
    a_err_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 8'd0)
        else $error("delimiter error outside closing beat");

    // a drain for string end always finishes with the closing beat
    a_flush_ends_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) && $past(flush_reg) |-> m_tvalid && m_tlast)
        else $error("string end drained without closing beat");

endmodule
